@@ hw/rtl/hhlp_pkg.sv @@
// Shared types and constants for the HTTP header line parser.
package hhlp_pkg;

  localparam int unsigned LenWidthDefault = 10;
  localparam int unsigned CfgWidth        = 10;
  localparam logic [CfgWidth-1:0] MaxValueLenReset = 10'd256;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [3:0] {
    StStart = 4'd0,
    StKey   = 4'd1,
    StColon = 4'd2,
    StSpace = 4'd3,
    StValue = 4'd4,
    StCr    = 4'd5,
    StLf    = 4'd6,
    StEndCr = 4'd7,
    StBody  = 4'd8,
    StError = 4'd9
  } parse_state_e;

  typedef enum logic [1:0] {
    RoleSkip  = 2'd0,
    RoleKey   = 2'd1,
    RoleValue = 2'd2,
    RoleBody  = 2'd3
  } byte_role_e;

  typedef struct packed {
    logic [7:0] data;
    byte_role_e role;
    logic       line_done;
    logic       headers_done;
    logic       parse_error;
  } byte_tag_t;

endpackage

@@ hw/rtl/hhlp_core.sv @@
// Header parse state machine with key and value length counters.
module hhlp_core #(
  parameter int unsigned LEN_WIDTH = hhlp_pkg::LenWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [7:0]                    byte_i,
  input  logic                          restart_i,
  input  logic [hhlp_pkg::CfgWidth-1:0] max_len_i,
  output hhlp_pkg::byte_tag_t           tag_o,
  output logic [LEN_WIDTH-1:0]          key_len_o,
  output logic [LEN_WIDTH-1:0]          val_len_o
);

  localparam int unsigned CmpWidth =
    (LEN_WIDTH > hhlp_pkg::CfgWidth) ? LEN_WIDTH : hhlp_pkg::CfgWidth;
  localparam logic [LEN_WIDTH-1:0] LenMax = {LEN_WIDTH{1'b1}};
  localparam logic [LEN_WIDTH-1:0] LenOne = LEN_WIDTH'(1);

  hhlp_pkg::parse_state_e state_q, state_d, state_cur;
  logic [LEN_WIDTH-1:0]   key_cnt_q, key_cnt_d, key_cnt_cur;
  logic [LEN_WIDTH-1:0]   val_cnt_q, val_cnt_d, val_cnt_cur;
  logic                   is_crlf;
  logic                   val_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hhlp_pkg::StStart;
      key_cnt_q <= '0;
      val_cnt_q <= '0;
    end else if (step_i) begin
      state_q   <= state_d;
      key_cnt_q <= key_cnt_d;
      val_cnt_q <= val_cnt_d;
    end
  end

  // restart clears the parser before this byte is handled
  assign state_cur   = restart_i ? hhlp_pkg::StStart : state_q;
  assign key_cnt_cur = restart_i ? '0 : key_cnt_q;
  assign val_cnt_cur = restart_i ? '0 : val_cnt_q;

  assign is_crlf  = (byte_i == hhlp_pkg::CharCr) || (byte_i == hhlp_pkg::CharLf);
  assign val_full = CmpWidth'(val_cnt_cur) >= CmpWidth'(max_len_i);

  always_comb begin
    state_d               = state_cur;
    key_cnt_d             = key_cnt_cur;
    val_cnt_d             = val_cnt_cur;
    tag_o.data            = byte_i;
    tag_o.role            = hhlp_pkg::RoleSkip;
    tag_o.line_done       = 1'b0;
    tag_o.headers_done    = 1'b0;
    key_len_o             = '0;
    val_len_o             = '0;
    unique case (state_cur)
      hhlp_pkg::StStart: begin
        if (!is_crlf) begin
          state_d    = hhlp_pkg::StKey;
          key_cnt_d  = LenOne;
          tag_o.role = hhlp_pkg::RoleKey;
        end
      end
      hhlp_pkg::StKey: begin
        if (byte_i == hhlp_pkg::CharColon) begin
          state_d = hhlp_pkg::StColon;
        end else if (is_crlf) begin
          state_d = hhlp_pkg::StError;
        end else begin
          if (key_cnt_cur != LenMax) key_cnt_d = key_cnt_cur + LenOne;
          tag_o.role = hhlp_pkg::RoleKey;
        end
      end
      hhlp_pkg::StColon: begin
        state_d = (byte_i == hhlp_pkg::CharSpace) ? hhlp_pkg::StSpace : hhlp_pkg::StError;
      end
      hhlp_pkg::StSpace: begin
        state_d    = hhlp_pkg::StValue;
        val_cnt_d  = LenOne;
        tag_o.role = hhlp_pkg::RoleValue;
      end
      hhlp_pkg::StValue: begin
        if (byte_i == hhlp_pkg::CharCr) begin
          state_d = hhlp_pkg::StCr;
        end else if (val_full) begin
          state_d = hhlp_pkg::StError;
        end else begin
          if (val_cnt_cur != LenMax) val_cnt_d = val_cnt_cur + LenOne;
          tag_o.role = hhlp_pkg::RoleValue;
        end
      end
      hhlp_pkg::StCr: begin
        if (byte_i == hhlp_pkg::CharLf) begin
          state_d         = hhlp_pkg::StLf;
          tag_o.line_done = 1'b1;
          key_len_o       = key_cnt_cur;
          val_len_o       = val_cnt_cur;
        end else begin
          state_d = hhlp_pkg::StError;
        end
      end
      hhlp_pkg::StLf: begin
        if (byte_i == hhlp_pkg::CharCr) begin
          state_d = hhlp_pkg::StEndCr;
        end else begin
          state_d    = hhlp_pkg::StKey;
          key_cnt_d  = LenOne;
          tag_o.role = hhlp_pkg::RoleKey;
        end
      end
      hhlp_pkg::StEndCr: begin
        if (byte_i == hhlp_pkg::CharLf) begin
          state_d            = hhlp_pkg::StBody;
          tag_o.headers_done = 1'b1;
        end else begin
          state_d = hhlp_pkg::StError;
        end
      end
      hhlp_pkg::StBody: begin
        tag_o.role = hhlp_pkg::RoleBody;
      end
      default: begin
        state_d = hhlp_pkg::StError;
      end
    endcase
    tag_o.parse_error = (state_d == hhlp_pkg::StError);
  end

endmodule

@@ hw/rtl/http_header_line_parser_unit.sv @@
// HTTP header line parser top level: parser core, output skid stage, config register.
// Takes one header byte per clock while in_stall_o is low and returns it tagged (skip,
// key, value, body) with line and end-of-header flags, key and value lengths of each
// completed line, and a sticky error flag. Every byte yields exactly one result,
// registered in the result or skid register and held only while the receiver stalls;
// the parse state updates as each byte is taken, so a byte may be accepted every clock.
// A two-entry output stage (result register plus skid register) keeps accepting while
// one result waits; in_stall_o rises only when both entries are full. Write
// max_value_len through the cfg port only while no byte is in flight; restart_i set
// with a byte clears the parse state before that byte is handled.
module http_header_line_parser_unit #(
  parameter int unsigned LEN_WIDTH = hhlp_pkg::LenWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic [1:0]                    byte_role_o,
  output logic                          line_done_o,
  output logic [LEN_WIDTH-1:0]          key_length_o,
  output logic [LEN_WIDTH-1:0]          value_length_o,
  output logic                          headers_done_o,
  output logic                          parse_error_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hhlp_pkg::CfgWidth-1:0] cfg_data_i
);

  logic [hhlp_pkg::CfgWidth-1:0] max_len_q;
  logic                          in_fire;
  logic                          out_fire;

  hhlp_pkg::byte_tag_t  tag_new;
  logic [LEN_WIDTH-1:0] key_len_new, val_len_new;

  logic                 main_valid_q, skid_valid_q;
  hhlp_pkg::byte_tag_t  main_tag_q, skid_tag_q;
  logic [LEN_WIDTH-1:0] main_key_q, skid_key_q, main_val_q, skid_val_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= hhlp_pkg::MaxValueLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_o && !out_stall_i;

  hhlp_core #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_fire),
    .byte_i    (in_byte_i),
    .restart_i (restart_i),
    .max_len_i (max_len_q),
    .tag_o     (tag_new),
    .key_len_o (key_len_new),
    .val_len_o (val_len_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || out_fire) begin
      // refill from skid first, it holds the older transaction
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || out_fire) begin
      if (skid_valid_q) begin
        main_tag_q <= skid_tag_q;
        main_key_q <= skid_key_q;
        main_val_q <= skid_val_q;
      end else if (in_fire) begin
        main_tag_q <= tag_new;
        main_key_q <= key_len_new;
        main_val_q <= val_len_new;
      end
    end else if (in_fire) begin
      skid_tag_q <= tag_new;
      skid_key_q <= key_len_new;
      skid_val_q <= val_len_new;
    end
  end

  assign out_valid_o    = main_valid_q;
  assign out_byte_o     = main_tag_q.data;
  assign byte_role_o    = main_tag_q.role;
  assign line_done_o    = main_tag_q.line_done;
  assign key_length_o   = main_key_q;
  assign value_length_o = main_val_q;
  assign headers_done_o = main_tag_q.headers_done;
  assign parse_error_o  = main_tag_q.parse_error;

  // skid entry only fills behind a waiting result
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry valid without a result in the output register");

  // a completed line always carries a key and a value byte
  a_line_lengths: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_done_o) |-> (key_length_o != '0 && value_length_o != '0))
    else $error("completed line reported with zero key or value length");

  // end of headers is a delimiter byte and not also a line end
  a_hdr_done_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && headers_done_o) |->
      (byte_role_o == hhlp_pkg::RoleSkip && !line_done_o && !parse_error_o))
    else $error("headers_done on a non-delimiter byte");

  // error bytes are never tagged as payload
  a_error_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && parse_error_o) |-> (byte_role_o == hhlp_pkg::RoleSkip))
    else $error("byte tagged with a role while in error state");

endmodule
